### hw/rtl/tfp_pkg.sv
// shared types and constants for the transaction field parser
`default_nettype none

package tfp_pkg;

   // largest count or script length that is decoded
   localparam logic [7:0] MAX_COUNT = 8'd252;

   // field lengths in bytes
   localparam logic [7:0] LEN_NONE    = 8'd0;
   localparam logic [7:0] LEN_SINGLE  = 8'd1;
   localparam logic [7:0] LEN_VERSION = 8'd4;
   localparam logic [7:0] LEN_INDEX   = 8'd4;
   localparam logic [7:0] LEN_SEQ     = 8'd4;
   localparam logic [7:0] LEN_VALUE   = 8'd8;
   localparam logic [7:0] LEN_TXID    = 8'd32;

   // parse phase, also the field kind reported with each word
   typedef enum logic [3:0] {
      PH_VERSION  = 4'd0,
      PH_MARKER   = 4'd1,
      PH_FLAG     = 4'd2,
      PH_INCOUNT  = 4'd3,
      PH_TXID     = 4'd4,
      PH_INDEX    = 4'd5,
      PH_SIGLEN   = 4'd6,
      PH_SIG      = 4'd7,
      PH_SEQUENCE = 4'd8,
      PH_OUTCOUNT = 4'd9,
      PH_VALUE    = 4'd10,
      PH_PKLEN    = 4'd11,
      PH_PKSCRIPT = 4'd12,
      PH_TRAILING = 4'd13
   } tfp_phase_type;

   // one incoming word
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       start_of_tx;
   } tfp_item_type;

   // one tagged result word
   typedef struct packed {
      logic [3:0] field_kind;
      logic [7:0] item_number;
      logic [7:0] byte_offset;
      logic [7:0] byte_value;
      logic       field_end;
      logic       parse_error;
   } tfp_result_type;

endpackage

`default_nettype wire

### hw/rtl/tfp_in_reg.sv
// input register stage holding one accepted word
`default_nettype none

module tfp_in_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic                 unload,
   input  wire logic [7:0]           tx_byte,
   input  wire logic                 start_of_tx,
   output logic                      item_valid,
   output tfp_pkg::tfp_item_type     item
);
   import tfp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   tfp_item_type item_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (unload) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.tx_byte     <= tx_byte;
         item_ff.start_of_tx <= start_of_tx;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

### hw/rtl/tfp_parser.sv
// parse state and per-word field tagging logic
`default_nettype none

module tfp_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire tfp_pkg::tfp_item_type  item,
   output tfp_pkg::tfp_result_type     result
);
   import tfp_pkg::*;

   tfp_phase_type phase_ff, phase_in;
   logic [7:0]    pos_ff, pos_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic [7:0]    tot_ff, tot_in;
   logic          err_ff, err_in;

   // state as seen by this word, after an optional restart
   tfp_phase_type cur_phase;
   logic [7:0]    cur_pos, cur_len, cur_cnt, cur_tot;
   logic          cur_err;

   logic [7:0]    b;
   logic [7:0]    pos_inc, cnt_inc;
   logic          over;
   tfp_phase_type kind;
   logic [7:0]    item_num, offset;
   logic          last;

   always_comb begin
      if (item.start_of_tx) begin
         cur_phase = PH_VERSION;
         cur_pos   = 8'd0;
         cur_len   = LEN_VERSION;
         cur_cnt   = 8'd0;
         cur_tot   = 8'd0;
         cur_err   = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_pos   = pos_ff;
         cur_len   = len_ff;
         cur_cnt   = cnt_ff;
         cur_tot   = tot_ff;
         cur_err   = err_ff;
      end
   end

   assign b       = item.tx_byte;
   assign pos_inc = cur_pos + 8'd1;
   assign cnt_inc = cur_cnt + 8'd1;
   assign over    = (b > MAX_COUNT);

   // next state
   always_comb begin
      phase_in = cur_phase;
      pos_in   = cur_pos;
      len_in   = cur_len;
      cnt_in   = cur_cnt;
      tot_in   = cur_tot;
      err_in   = cur_err;
      case (cur_phase)
         PH_MARKER, PH_INCOUNT: begin
            if (cur_phase == PH_MARKER && b == 8'd0) begin
               phase_in = PH_FLAG;
               pos_in   = 8'd0;
               len_in   = LEN_SINGLE;
            end else if (over) begin
               err_in   = 1'b1;
               phase_in = PH_TRAILING;
               pos_in   = 8'd0;
               len_in   = LEN_NONE;
            end else begin
               tot_in = b;
               cnt_in = 8'd0;
               pos_in = 8'd0;
               if (b == 8'd0) begin
                  phase_in = PH_OUTCOUNT;
                  len_in   = LEN_SINGLE;
               end else begin
                  phase_in = PH_TXID;
                  len_in   = LEN_TXID;
               end
            end
         end
         PH_FLAG: begin
            phase_in = PH_INCOUNT;
            pos_in   = 8'd0;
            len_in   = LEN_SINGLE;
         end
         PH_SIGLEN: begin
            pos_in = 8'd0;
            if (over) begin
               err_in   = 1'b1;
               phase_in = PH_TRAILING;
               len_in   = LEN_NONE;
            end else if (b == 8'd0) begin
               phase_in = PH_SEQUENCE;
               len_in   = LEN_SEQ;
            end else begin
               phase_in = PH_SIG;
               len_in   = b;
            end
         end
         PH_OUTCOUNT: begin
            pos_in = 8'd0;
            if (over) begin
               err_in   = 1'b1;
               phase_in = PH_TRAILING;
               len_in   = LEN_NONE;
            end else begin
               tot_in = b;
               cnt_in = 8'd0;
               if (b == 8'd0) begin
                  phase_in = PH_TRAILING;
                  len_in   = LEN_NONE;
               end else begin
                  phase_in = PH_VALUE;
                  len_in   = LEN_VALUE;
               end
            end
         end
         PH_PKLEN: begin
            pos_in = 8'd0;
            if (over) begin
               err_in   = 1'b1;
               phase_in = PH_TRAILING;
               len_in   = LEN_NONE;
            end else if (b == 8'd0) begin
               // empty script: straight on to the next output, or to trailing after the last one
               cnt_in = cnt_inc;
               if (cnt_inc >= cur_tot) begin
                  phase_in = PH_TRAILING;
                  len_in   = LEN_NONE;
               end else begin
                  phase_in = PH_VALUE;
                  len_in   = LEN_VALUE;
               end
            end else begin
               phase_in = PH_PKSCRIPT;
               len_in   = b;
            end
         end
         PH_VERSION, PH_TXID, PH_INDEX, PH_SIG, PH_SEQUENCE, PH_VALUE,
         PH_PKSCRIPT: begin
            if (pos_inc < cur_len) begin
               pos_in = pos_inc;
            end else begin
               pos_in = 8'd0;
               case (cur_phase)
                  PH_VERSION: begin
                     phase_in = PH_MARKER;
                     len_in   = LEN_SINGLE;
                  end
                  PH_TXID: begin
                     phase_in = PH_INDEX;
                     len_in   = LEN_INDEX;
                  end
                  PH_INDEX: begin
                     phase_in = PH_SIGLEN;
                     len_in   = LEN_SINGLE;
                  end
                  PH_SIG: begin
                     phase_in = PH_SEQUENCE;
                     len_in   = LEN_SEQ;
                  end
                  PH_SEQUENCE: begin
                     cnt_in = cnt_inc;
                     if (cnt_inc >= cur_tot) begin
                        phase_in = PH_OUTCOUNT;
                        len_in   = LEN_SINGLE;
                     end else begin
                        phase_in = PH_TXID;
                        len_in   = LEN_TXID;
                     end
                  end
                  PH_VALUE: begin
                     phase_in = PH_PKLEN;
                     len_in   = LEN_SINGLE;
                  end
                  default: begin
                     cnt_in = cnt_inc;
                     if (cnt_inc >= cur_tot) begin
                        phase_in = PH_TRAILING;
                        len_in   = LEN_NONE;
                     end else begin
                        phase_in = PH_VALUE;
                        len_in   = LEN_VALUE;
                     end
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_TRAILING;
            pos_in   = 8'd0;
            len_in   = LEN_NONE;
         end
      endcase
   end

   // tag for this word
   always_comb begin
      kind     = cur_phase;
      item_num = 8'd0;
      offset   = 8'd0;
      last     = 1'b1;
      case (cur_phase)
         PH_MARKER: begin
            if (b != 8'd0) begin
               kind = PH_INCOUNT;
            end
         end
         PH_FLAG, PH_INCOUNT, PH_OUTCOUNT: begin
            kind = cur_phase;
         end
         PH_SIGLEN, PH_PKLEN: begin
            item_num = cur_cnt;
         end
         PH_VERSION: begin
            offset = cur_pos;
            last   = (pos_inc >= cur_len);
         end
         PH_TXID, PH_INDEX, PH_SIG, PH_SEQUENCE, PH_VALUE, PH_PKSCRIPT: begin
            item_num = cur_cnt;
            offset   = cur_pos;
            last     = (pos_inc >= cur_len);
         end
         default: begin
            kind = PH_TRAILING;
            last = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VERSION;
         pos_ff   <= 8'd0;
         len_ff   <= LEN_VERSION;
         cnt_ff   <= 8'd0;
         tot_ff   <= 8'd0;
         err_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         tot_ff   <= tot_in;
         err_ff   <= err_in;
      end
   end

   assign result.field_kind  = kind;
   assign result.item_number = item_num;
   assign result.byte_offset = offset;
   assign result.byte_value  = b;
   assign result.field_end   = last;
   assign result.parse_error = err_in;

endmodule

`default_nettype wire

### hw/rtl/tfp_out_reg.sv
// result register driving the response channel
`default_nettype none

module tfp_out_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    result_valid,
   input  wire tfp_pkg::tfp_result_type result,
   output logic                         rsp_valid,
   output logic [3:0]                   rsp_field_kind,
   output logic [7:0]                   rsp_item_number,
   output logic [7:0]                   rsp_byte_offset,
   output logic [7:0]                   rsp_byte_value,
   output logic                         rsp_field_end,
   output logic                         rsp_parse_error
);
   import tfp_pkg::*;

   logic           valid_ff;
   tfp_result_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_field_kind  = data_ff.field_kind;
   assign rsp_item_number = data_ff.item_number;
   assign rsp_byte_offset = data_ff.byte_offset;
   assign rsp_byte_value  = data_ff.byte_value;
   assign rsp_field_end   = data_ff.field_end;
   assign rsp_parse_error = data_ff.parse_error;

endmodule

`default_nettype wire

### hw/rtl/transaction_field_parser.sv
// top level of the transaction field parser
//
// usage:
//  - req channel: one raw transaction byte per word (req_tx_byte), with
//    req_start_of_tx high on the first byte of a new transaction; the
//    parser restarts on that word, which is taken as version byte 0
//  - rsp channel: one tagged word per request word, in order: field kind,
//    input/output item number, offset within the field in wire order,
//    the byte itself, end-of-field and the sticky parse error flag
//  - a word moves when valid is high and stall is low at a clock edge
//  - a word accepted into the input register is tagged by the parser on
//    its way into the result register, which drives it onto rsp
//  - throughput: one word per cycle while rsp_stall stays low; the parse
//    state is a single register set updated in one step, so the parser never holds a byte back
//  - stalls: while rsp_stall holds, the result register keeps its word
//    and the input register can still take one more word before
//    req_stall rises
//  - reset (synchronous, active high) empties both registers and puts
//    the parser at version byte 0 with the error flag clear
`default_nettype none

module transaction_field_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_tx_byte,
   input  wire logic       req_start_of_tx,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_field_kind,
   output logic [7:0]      rsp_item_number,
   output logic [7:0]      rsp_byte_offset,
   output logic [7:0]      rsp_byte_value,
   output logic            rsp_field_end,
   output logic            rsp_parse_error
);
   import tfp_pkg::*;

   logic           in_valid;
   tfp_item_type   in_item;
   tfp_result_type result;
   logic           advance;
   logic           req_accept;
   logic           step;

   // result register can load when empty or being drained this cycle
   assign advance    = !rsp_valid || !rsp_stall;
   // input register holds its word only when it cannot move on
   assign req_stall  = in_valid && !advance;
   assign req_accept = req_valid && !req_stall;
   // parse state advances exactly when a word moves into the result register
   assign step       = in_valid && advance;

   tfp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (req_accept),
      .unload      (advance),
      .tx_byte     (req_tx_byte),
      .start_of_tx (req_start_of_tx),
      .item_valid  (in_valid),
      .item        (in_item)
   );

   // field tagging and state update, all between the two registers
   tfp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item),
      .result (result)
   );

   tfp_out_reg u_out_reg (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .result_valid    (in_valid),
      .result          (result),
      .rsp_valid       (rsp_valid),
      .rsp_field_kind  (rsp_field_kind),
      .rsp_item_number (rsp_item_number),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_field_end   (rsp_field_end),
      .rsp_parse_error (rsp_parse_error)
   );

`ifndef NO_ASSERTIONS
   // a new word never lands on a held word that cannot move
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!in_valid || advance))
      else $error("input word overwritten while held");

   // a held input word is still there next cycle
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !advance) |=> in_valid)
      else $error("held input word lost");

   // trailing words carry no position information
   a_trailing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_field_kind == PH_TRAILING) |->
      (!rsp_field_end && rsp_byte_offset == 8'd0 && rsp_item_number == 8'd0))
      else $error("trailing word with position tags");

   // single-byte fields always end on their one byte
   a_single_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_field_kind == PH_MARKER || rsp_field_kind == PH_FLAG ||
                     rsp_field_kind == PH_INCOUNT || rsp_field_kind == PH_SIGLEN ||
                     rsp_field_kind == PH_OUTCOUNT || rsp_field_kind == PH_PKLEN)) |->
      (rsp_field_end && rsp_byte_offset == 8'd0))
      else $error("single-byte field not closed");

   // version bytes stay within the four-byte field
   a_version: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_field_kind == PH_VERSION) |->
      (rsp_item_number == 8'd0 && rsp_byte_offset < LEN_VERSION))
      else $error("version byte out of range");
`endif

endmodule

`default_nettype wire
